@@ rtl/sbm_pkg.sv @@
// Shared types, codes and helper functions for the sensor bus master.
// Used by sbm_seq and sensor_bus_master_with_crc; depends on nothing.
package sbm_pkg;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_CR_LO = 4'd1,
		ST_CR_HI = 4'd2,
		ST_START = 4'd3,
		ST_WR_LO = 4'd4,
		ST_WR_HI = 4'd5,
		ST_WAIT  = 4'd6,
		ST_RD_LO = 4'd7,
		ST_RD_HI = 4'd8,
		ST_END   = 4'd9
	} step_t;

	localparam logic [2:0] OP_NONE      = 3'd0;
	localparam logic [2:0] OP_TEMP      = 3'd1;
	localparam logic [2:0] OP_HUMI      = 3'd2;
	localparam logic [2:0] OP_STAT_RD   = 3'd3;
	localparam logic [2:0] OP_STAT_WR   = 3'd4;
	localparam logic [2:0] OP_SOFT_RST  = 3'd5;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_NO_ACK   = 2'd1;
	localparam logic [1:0] ERR_TIMEOUT  = 2'd2;
	localparam logic [1:0] ERR_CHECKSUM = 2'd3;

	localparam logic [2:0] REG_HALF_PERIOD = 3'd0;
	localparam logic [2:0] REG_POLL_INTV   = 3'd1;
	localparam logic [2:0] REG_TIMEOUT     = 3'd2;
	localparam logic [2:0] REG_CMD_TEMP    = 3'd3;
	localparam logic [2:0] REG_CMD_HUMI    = 3'd4;
	localparam logic [2:0] REG_CMD_STAT_RD = 3'd5;
	localparam logic [2:0] REG_CMD_STAT_WR = 3'd6;
	localparam logic [2:0] REG_CMD_SOFT    = 3'd7;

	localparam logic [7:0] CRC_POLY = 8'h31;

	// Start pattern, phase i in bit i.
	localparam logic [6:0] START_SCK  = 7'b0110110;
	localparam logic [6:0] START_PULL = 7'b0011100;

	typedef struct packed {
		logic [7:0]  half_period;
		logic [15:0] poll_interval;
		logic [15:0] timeout_polls;
		logic [7:0]  cmd_temp;
		logic [7:0]  cmd_humi;
		logic [7:0]  cmd_stat_rd;
		logic [7:0]  cmd_stat_wr;
		logic [7:0]  cmd_soft;
	} cfg_t;

	typedef struct packed {
		logic        sck;
		logic        data_pull_low;
		logic        busy;
		logic        done;
		logic [15:0] read_value;
		logic [7:0]  read_checksum;
		logic [1:0]  error_code;
	} res_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

endpackage

@@ rtl/sbm_seq.sv @@
// Transaction sequencer of the sensor bus master: state registers and the
// per-tick next-state logic. Depends on sbm_pkg.
module sbm_seq #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic [2:0]    op,
	input  logic [7:0]    write_value,
	input  logic          data_line,
	input  sbm_pkg::cfg_t cfg,
	output sbm_pkg::res_t res
);
	import sbm_pkg::*;

	localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
	localparam logic [CW-1:0] TMAX = {CW{1'b1}} >> (CW - TIMER_WIDTH);

	step_t                  step_q, step_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic [3:0]             bit_q, bit_d;
	logic [1:0]             byte_q, byte_d;
	logic [7:0]             shift_q, shift_d;
	logic [2:0]             kind_q, kind_d;
	logic [15:0]            poll_q, poll_d;
	logic [15:0]            value_q, value_d;
	logic [7:0]             chk_q, chk_d;
	logic [7:0]             crc_q, crc_d;
	logic [1:0]             err_q, err_d;

	logic                   sck, pull, done;
	logic                   measure;
	logic [7:0]             cmd;
	logic [7:0]             half;
	logic [15:0]            poll_iv;
	logic [CW-1:0]          poll_iv_ext;

	assign measure     = (kind_q == OP_TEMP) || (kind_q == OP_HUMI);
	assign half        = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
	assign poll_iv     = (cfg.poll_interval == 16'd0) ? 16'd0 : cfg.poll_interval - 16'd1;
	assign poll_iv_ext = CW'(poll_iv);

	always_comb begin
		step_d  = step_q;
		timer_d = timer_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		shift_d = shift_q;
		kind_d  = kind_q;
		poll_d  = poll_q;
		value_d = value_q;
		chk_d   = chk_q;
		crc_d   = crc_q;
		err_d   = err_q;
		sck     = 1'b0;
		pull    = 1'b0;
		done    = 1'b0;
		cmd     = cfg.cmd_soft;

		if (step_q == ST_IDLE) begin
			if (op inside {[OP_TEMP:OP_SOFT_RST]}) begin
				kind_d  = op;
				err_d   = ERR_OK;
				chk_d   = 8'd0;
				crc_d   = 8'd0;
				value_d = 16'd0;
				poll_d  = 16'd0;
				bit_d   = 4'd0;
				byte_d  = 2'd0;
				timer_d = '0;
				case (op)
					OP_TEMP: cmd = cfg.cmd_temp;
					OP_HUMI: cmd = cfg.cmd_humi;
					OP_STAT_RD: cmd = cfg.cmd_stat_rd;
					OP_STAT_WR: begin
						cmd     = cfg.cmd_stat_wr;
						value_d = {8'd0, write_value};
					end
					default: cmd = cfg.cmd_soft;
				endcase
				shift_d = cmd;
				if (op == OP_TEMP || op == OP_HUMI) begin
					crc_d = crc8_update(8'd0, cmd);
				end
				step_d = (op == OP_SOFT_RST) ? ST_CR_LO : ST_START;
			end
		end else begin
			case (step_q)
				ST_CR_HI: sck = 1'b1;
				ST_START: begin
					if (bit_q < 4'd7) begin
						sck  = START_SCK[bit_q[2:0]];
						pull = START_PULL[bit_q[2:0]];
					end
				end
				ST_WR_LO, ST_WR_HI: begin
					sck = (step_q == ST_WR_HI);
					if (bit_q < 4'd8) begin
						pull = ~shift_q[~bit_q[2:0]];
					end
				end
				ST_RD_LO, ST_RD_HI: begin
					sck = (step_q == ST_RD_HI);
					if (bit_q >= 4'd8) begin
						pull = (byte_q < 2'd2);
					end
				end
				default: ;
			endcase

			if (step_q == ST_WAIT) begin
				if (timer_q != '0) begin
					timer_d = timer_q - TIMER_WIDTH'(1);
				end else if (poll_q >= cfg.timeout_polls) begin
					err_d  = ERR_TIMEOUT;
					step_d = ST_END;
				end else if (!data_line) begin
					byte_d  = 2'd0;
					bit_d   = 4'd0;
					shift_d = 8'd0;
					step_d  = ST_RD_LO;
				end else begin
					poll_d  = poll_q + 16'd1;
					timer_d = (poll_iv_ext > TMAX) ? TIMER_WIDTH'(TMAX)
					                               : TIMER_WIDTH'(poll_iv_ext);
				end
			end else if (({1'b0, timer_q} + (TIMER_WIDTH + 1)'(1))
			             >= (TIMER_WIDTH + 1)'(half)) begin
				timer_d = '0;
				case (step_q)
					ST_CR_LO: step_d = ST_CR_HI;
					ST_CR_HI: begin
						if (bit_q >= 4'd8) begin
							bit_d  = 4'd0;
							step_d = ST_START;
						end else begin
							bit_d  = bit_q + 4'd1;
							step_d = ST_CR_LO;
						end
					end
					ST_START: begin
						if (bit_q >= 4'd6) begin
							bit_d  = 4'd0;
							step_d = ST_WR_LO;
						end else begin
							bit_d = bit_q + 4'd1;
						end
					end
					ST_WR_LO: step_d = ST_WR_HI;
					ST_WR_HI: begin
						if (bit_q < 4'd8) begin
							bit_d  = bit_q + 4'd1;
							step_d = ST_WR_LO;
						end else begin
							bit_d = 4'd0;
							if (data_line) begin
								err_d  = ERR_NO_ACK;
								step_d = ST_END;
							end else if (kind_q == OP_STAT_WR && byte_q == 2'd0) begin
								byte_d  = 2'd1;
								shift_d = value_q[7:0];
								step_d  = ST_WR_LO;
							end else if (measure) begin
								poll_d = 16'd0;
								step_d = ST_WAIT;
							end else if (kind_q == OP_STAT_RD) begin
								byte_d  = 2'd1;
								shift_d = 8'd0;
								step_d  = ST_RD_LO;
							end else begin
								step_d = ST_END;
							end
						end
					end
					ST_RD_LO: step_d = ST_RD_HI;
					ST_RD_HI: begin
						if (bit_q < 4'd8) begin
							shift_d = {shift_q[6:0], data_line};
							bit_d   = bit_q + 4'd1;
							step_d  = ST_RD_LO;
						end else begin
							bit_d = 4'd0;
							if (byte_q == 2'd0) begin
								value_d = {shift_q, 8'd0};
								crc_d   = crc8_update(crc_q, shift_q);
							end else if (byte_q == 2'd1) begin
								value_d = {value_q[15:8], shift_q};
								crc_d   = crc8_update(crc_q, shift_q);
							end else begin
								chk_d = shift_q;
							end
							if (byte_q >= 2'd2) begin
								if (measure && reverse8(crc_q) != shift_q) begin
									err_d = ERR_CHECKSUM;
								end
								step_d = ST_END;
							end else begin
								byte_d  = byte_q + 2'd1;
								shift_d = 8'd0;
								step_d  = ST_RD_LO;
							end
						end
					end
					ST_END: begin
						step_d = ST_IDLE;
						done   = 1'b1;
					end
					default: step_d = ST_IDLE;
				endcase
			end else begin
				timer_d = timer_q + TIMER_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			timer_q <= '0;
			bit_q   <= 4'd0;
			byte_q  <= 2'd0;
			shift_q <= 8'd0;
			kind_q  <= OP_NONE;
			poll_q  <= 16'd0;
			value_q <= 16'd0;
			chk_q   <= 8'd0;
			crc_q   <= 8'd0;
			err_q   <= ERR_OK;
		end else if (adv) begin
			step_q  <= step_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			shift_q <= shift_d;
			kind_q  <= kind_d;
			poll_q  <= poll_d;
			value_q <= value_d;
			chk_q   <= chk_d;
			crc_q   <= crc_d;
			err_q   <= err_d;
		end
	end

	assign res.sck           = sck;
	assign res.data_pull_low = pull;
	assign res.busy          = (step_d != ST_IDLE);
	assign res.done          = done;
	assign res.read_value    = value_d;
	assign res.read_checksum = chk_d;
	assign res.error_code    = err_d;

endmodule

@@ rtl/sensor_bus_master_with_crc.sv @@
// Top level of the two-wire sensor bus master: stream ports, configuration
// registers and the result register. Depends on sbm_pkg and sbm_seq.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  one tick: request, write byte, data line
//   m_*      out        m_tvalid/m_tready  one tick: line levels, status, read data
//   cfg_*    in         cfg_valid/cfg_ready register index and value
//
// Every input transfer yields exactly one output transfer. One transfer per
// cycle is sustained while m_tready is high; the sequencer registers advance
// once per input transfer, and the single result register decouples the two sides.
// A stalled output holds its result and blocks input only while it is full.
// Reset returns the sequencer to idle and the config registers to their defaults.
module sensor_bus_master_with_crc #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] op, [10:3] write_value, [11] data_line, [15:12] zero
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] sck, [1] data_pull_low, [2] busy_res, [3] done_res,
	// [19:4] read_value, [27:20] read_checksum, [29:28] error_code, [31:30] zero
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sbm_pkg::*;

	cfg_t        cfg_q;
	res_t        res;
	logic        adv;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	assign s_tready  = !out_valid_q || m_tready;
	assign adv       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period   <= 8'd5;
			cfg_q.poll_interval <= 16'd100;
			cfg_q.timeout_polls <= 16'd20000;
			cfg_q.cmd_temp      <= 8'd3;
			cfg_q.cmd_humi      <= 8'd5;
			cfg_q.cmd_stat_rd   <= 8'd7;
			cfg_q.cmd_stat_wr   <= 8'd6;
			cfg_q.cmd_soft      <= 8'd30;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_PERIOD: cfg_q.half_period   <= cfg_data[7:0];
				REG_POLL_INTV:   cfg_q.poll_interval <= cfg_data;
				REG_TIMEOUT:     cfg_q.timeout_polls <= cfg_data;
				REG_CMD_TEMP:    cfg_q.cmd_temp      <= cfg_data[7:0];
				REG_CMD_HUMI:    cfg_q.cmd_humi      <= cfg_data[7:0];
				REG_CMD_STAT_RD: cfg_q.cmd_stat_rd   <= cfg_data[7:0];
				REG_CMD_STAT_WR: cfg_q.cmd_stat_wr   <= cfg_data[7:0];
				REG_CMD_SOFT:    cfg_q.cmd_soft      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	sbm_seq #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.op         (s_tdata[2:0]),
		.write_value(s_tdata[10:3]),
		.data_line  (s_tdata[11]),
		.cfg        (cfg_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {2'b00, res.error_code, res.read_checksum, res.read_value,
			               res.done, res.busy, res.data_pull_low, res.sck};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ sim/tb_top.sv @@
// Testbench for sensor_bus_master_with_crc: drives one bus tick per transfer, emulates the
// sensor's answers and checks every output transfer against a tick-level predictor.
// Depends on sbm_pkg and the sensor_bus_master_with_crc RTL.
`timescale 1ns / 100ps

module tb_top;
	import sbm_pkg::*;

	localparam int TIMER_W = 16;
	localparam int TIMER_MAX = (1 << TIMER_W) - 1;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam logic [1:0] NACK_NONE = 2'd3;
	localparam logic [6:0] START_CLK = 7'b0110110;
	localparam logic [6:0] START_DAT = 7'b0011100;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	sensor_bus_master_with_crc #(.TIMER_WIDTH(TIMER_W)) dut (.*);

	// Predicted sequencer state and shadow registers.
	step_t              seq_step;
	logic [TIMER_W-1:0] ph_timer;
	logic [3:0]         bit_cnt;
	logic [1:0]         byte_idx;
	logic [7:0]         shreg;
	logic [2:0]         req_kind;
	logic [15:0]        polls;
	logic [15:0]        value_q;
	logic [7:0]         sum_q;
	logic [7:0]         crc_q;
	logic [1:0]         err_q;
	cfg_t               bus_cfg;

	// Planned sensor behavior for the current transaction.
	logic [7:0] rsp_msb;
	logic [7:0] rsp_lsb;
	logic [7:0] rsp_sum;
	logic [1:0] nack_at;
	int         answer_after;
	bit         sens_noise;

	bit   gaps_on;
	int   fail_count;
	res_t line_status_q[$];
	res_t want_r;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] crc31_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
		end
		return c;
	endfunction

	function automatic logic [7:0] flip_byte(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[7 - i] = v[i];
		return r;
	endfunction

	function automatic cfg_t reset_cfg();
		cfg_t c;
		c.half_period = 8'd5;
		c.poll_interval = 16'd100;
		c.timeout_polls = 16'd20000;
		c.cmd_temp = 8'd3;
		c.cmd_humi = 8'd5;
		c.cmd_stat_rd = 8'd7;
		c.cmd_stat_wr = 8'd6;
		c.cmd_soft = 8'd30;
		return c;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic res_t bus_tick(input logic [2:0] op, input logic [7:0] wv, input logic d);
		res_t       r;
		logic [7:0] half;
		logic [7:0] cmd;
		int         iv;
		bit         measure;
		r = '0;
		measure = (req_kind == OP_TEMP) || (req_kind == OP_HUMI);
		if (seq_step == ST_IDLE) begin
			if (op >= OP_TEMP && op <= OP_SOFT_RST) begin
				req_kind = op;
				err_q = ERR_OK;
				sum_q = '0;
				crc_q = '0;
				value_q = '0;
				polls = '0;
				bit_cnt = '0;
				byte_idx = '0;
				ph_timer = '0;
				case (op)
					OP_TEMP: cmd = bus_cfg.cmd_temp;
					OP_HUMI: cmd = bus_cfg.cmd_humi;
					OP_STAT_RD: cmd = bus_cfg.cmd_stat_rd;
					OP_STAT_WR: begin
						cmd = bus_cfg.cmd_stat_wr;
						value_q = {8'h00, wv};
					end
					default: cmd = bus_cfg.cmd_soft;
				endcase
				shreg = cmd;
				if (op == OP_TEMP || op == OP_HUMI) crc_q = crc31_byte(8'h00, cmd);
				seq_step = (op == OP_SOFT_RST) ? ST_CR_LO : ST_START;
			end
		end else begin
			case (seq_step)
				ST_CR_HI: r.sck = 1'b1;
				ST_START: if (bit_cnt < 7) begin
					r.sck = START_CLK[bit_cnt];
					r.data_pull_low = START_DAT[bit_cnt];
				end
				ST_WR_LO, ST_WR_HI: begin
					r.sck = (seq_step == ST_WR_HI);
					if (bit_cnt < 8) r.data_pull_low = !shreg[7 - bit_cnt];
				end
				ST_RD_LO, ST_RD_HI: begin
					r.sck = (seq_step == ST_RD_HI);
					if (bit_cnt >= 8) r.data_pull_low = (byte_idx < 2);
				end
				default: ;
			endcase
			if (seq_step == ST_WAIT) begin
				if (ph_timer != 0) begin
					ph_timer = ph_timer - TIMER_W'(1);
				end else if (polls >= bus_cfg.timeout_polls) begin
					err_q = ERR_TIMEOUT;
					seq_step = ST_END;
				end else if (!d) begin
					byte_idx = '0;
					bit_cnt = '0;
					shreg = '0;
					seq_step = ST_RD_LO;
				end else begin
					polls = polls + 16'd1;
					iv = (bus_cfg.poll_interval == 0) ? 0 : int'(bus_cfg.poll_interval) - 1;
					ph_timer = TIMER_W'((iv > TIMER_MAX) ? TIMER_MAX : iv);
				end
			end else begin
				half = (bus_cfg.half_period == 0) ? 8'd1 : bus_cfg.half_period;
				if (int'(ph_timer) + 1 >= int'(half)) begin
					ph_timer = '0;
					case (seq_step)
						ST_CR_LO: seq_step = ST_CR_HI;
						ST_CR_HI: begin
							if (bit_cnt >= 8) begin
								bit_cnt = '0;
								seq_step = ST_START;
							end else begin
								bit_cnt = bit_cnt + 4'd1;
								seq_step = ST_CR_LO;
							end
						end
						ST_START: begin
							if (bit_cnt >= 6) begin
								bit_cnt = '0;
								seq_step = ST_WR_LO;
							end else begin
								bit_cnt = bit_cnt + 4'd1;
							end
						end
						ST_WR_LO: seq_step = ST_WR_HI;
						ST_WR_HI: begin
							if (bit_cnt < 8) begin
								bit_cnt = bit_cnt + 4'd1;
								seq_step = ST_WR_LO;
							end else begin
								bit_cnt = '0;
								if (d) begin
									err_q = ERR_NO_ACK;
									seq_step = ST_END;
								end else if (req_kind == OP_STAT_WR && byte_idx == 0) begin
									byte_idx = 2'd1;
									shreg = value_q[7:0];
									seq_step = ST_WR_LO;
								end else if (measure) begin
									polls = '0;
									seq_step = ST_WAIT;
								end else if (req_kind == OP_STAT_RD) begin
									byte_idx = 2'd1;
									shreg = '0;
									seq_step = ST_RD_LO;
								end else begin
									seq_step = ST_END;
								end
							end
						end
						ST_RD_LO: seq_step = ST_RD_HI;
						ST_RD_HI: begin
							if (bit_cnt < 8) begin
								shreg = {shreg[6:0], d};
								bit_cnt = bit_cnt + 4'd1;
								seq_step = ST_RD_LO;
							end else begin
								if (byte_idx == 0) begin
									value_q = {shreg, 8'h00};
									crc_q = crc31_byte(crc_q, shreg);
								end else if (byte_idx == 1) begin
									value_q[7:0] = shreg;
									crc_q = crc31_byte(crc_q, shreg);
								end else begin
									sum_q = shreg;
								end
								bit_cnt = '0;
								if (byte_idx >= 2) begin
									if (measure && flip_byte(crc_q) != sum_q) err_q = ERR_CHECKSUM;
									seq_step = ST_END;
								end else begin
									byte_idx = byte_idx + 2'd1;
									shreg = '0;
									seq_step = ST_RD_LO;
								end
							end
						end
						ST_END: begin
							seq_step = ST_IDLE;
							r.done = 1'b1;
						end
						default: seq_step = ST_IDLE;
					endcase
				end else begin
					ph_timer = ph_timer + TIMER_W'(1);
				end
			end
		end
		r.busy = (seq_step != ST_IDLE);
		r.read_value = value_q;
		r.read_checksum = sum_q;
		r.error_code = err_q;
		return r;
	endfunction

	// Level the emulated sensor puts on the data line for the next tick.
	function automatic logic sensor_line();
		logic [7:0] b;
		if (sens_noise) return 1'($urandom_range(0, 1));
		case (seq_step)
			ST_WR_HI: if (bit_cnt == 8) return (nack_at == byte_idx);
			ST_WAIT: return (int'(polls) < answer_after);
			ST_RD_HI: if (bit_cnt < 8) begin
				b = (byte_idx == 0) ? rsp_msb : (byte_idx == 1) ? rsp_lsb : rsp_sum;
				return b[7 - bit_cnt];
			end
			default: ;
		endcase
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (line_status_q.size() == 0) begin
				$error("output transfer with no expected result");
				fail_count++;
			end else begin
				want_r = line_status_q.pop_front();
				check_field("sck", want_r.sck, m_tdata[0]);
				check_field("data_pull_low", want_r.data_pull_low, m_tdata[1]);
				check_field("busy_res", want_r.busy, m_tdata[2]);
				check_field("done_res", want_r.done, m_tdata[3]);
				check_field("read_value", want_r.read_value, m_tdata[19:4]);
				check_field("read_checksum", want_r.read_checksum, m_tdata[27:20]);
				check_field("error_code", want_r.error_code, m_tdata[29:28]);
			end
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_tick(input logic [2:0] op, input logic [7:0] wv);
		logic d;
		d = sensor_line();
		s_tvalid <= 1'b1;
		s_tdata <= {4'h0, d, wv, op};
		do @(posedge clk); while (!s_tready);
		line_status_q.push_back(bus_tick(op, wv, d));
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (line_status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_cfg(input cfg_t c);
		settle();
		cfg_put(REG_HALF_PERIOD, {8'h00, c.half_period});
		cfg_put(REG_POLL_INTV, c.poll_interval);
		cfg_put(REG_TIMEOUT, c.timeout_polls);
		cfg_put(REG_CMD_TEMP, {8'h00, c.cmd_temp});
		cfg_put(REG_CMD_HUMI, {8'h00, c.cmd_humi});
		cfg_put(REG_CMD_STAT_RD, {8'h00, c.cmd_stat_rd});
		cfg_put(REG_CMD_STAT_WR, {8'h00, c.cmd_stat_wr});
		cfg_put(REG_CMD_SOFT, {8'h00, c.cmd_soft});
		cfg_valid <= 1'b0;
		bus_cfg = c;
	endtask

	function automatic logic [2:0] idle_op();
		case ($urandom_range(0, 2))
			0: return OP_NONE;
			1: return OP_SPARE6;
			default: return OP_SPARE7;
		endcase
	endfunction

	// One request from idle back to idle, with requests thrown at it while busy.
	task automatic run_request(input logic [2:0] op, input logic [7:0] wv, input int answer,
			input logic [1:0] nack, input bit bad_sum, input bit noise);
		logic [7:0] cmd;
		case (op)
			OP_TEMP: cmd = bus_cfg.cmd_temp;
			OP_HUMI: cmd = bus_cfg.cmd_humi;
			OP_STAT_RD: cmd = bus_cfg.cmd_stat_rd;
			OP_STAT_WR: cmd = bus_cfg.cmd_stat_wr;
			default: cmd = bus_cfg.cmd_soft;
		endcase
		rsp_msb = 8'($urandom);
		rsp_lsb = 8'($urandom);
		rsp_sum = flip_byte(crc31_byte(crc31_byte(crc31_byte(8'h00, cmd), rsp_msb), rsp_lsb));
		if (bad_sum) rsp_sum = rsp_sum ^ 8'($urandom_range(1, 255));
		answer_after = answer;
		nack_at = nack;
		sens_noise = noise;
		send_tick(op, wv);
		while (seq_step != ST_IDLE) send_tick(3'($urandom_range(0, 7)), 8'($urandom));
		repeat ($urandom_range(0, 2)) send_tick(idle_op(), 8'($urandom));
	endtask

	task automatic test_ignored_ops();
		send_tick(OP_NONE, 8'hFF);
		send_tick(OP_SPARE6, 8'h00);
		send_tick(OP_SPARE7, 8'hFF);
		send_tick(OP_NONE, 8'h00);
	endtask

	task automatic test_requests();
		cfg_t c;
		run_request(OP_TEMP, 8'($urandom), 0, 2'd0, 1'b0, 1'b0);
		c = reset_cfg();
		c.half_period = 8'd1;
		c.poll_interval = 16'd2;
		program_cfg(c);
		run_request(OP_TEMP, 8'($urandom), 1, NACK_NONE, 1'b0, 1'b0);
		run_request(OP_STAT_WR, 8'hFF, 0, NACK_NONE, 1'b0, 1'b0);
		run_request(OP_SOFT_RST, 8'($urandom), 0, NACK_NONE, 1'b0, 1'b0);
	endtask

	task automatic test_error_paths();
		cfg_t c;
		c = reset_cfg();
		c.half_period = 8'd1;
		c.poll_interval = 16'd3;
		c.timeout_polls = 16'd2;
		program_cfg(c);
		run_request(OP_STAT_WR, 8'hA5, 0, 2'd1, 1'b0, 1'b0);
		run_request(OP_TEMP, 8'($urandom), 5, NACK_NONE, 1'b0, 1'b0);
		run_request(OP_HUMI, 8'($urandom), 1, NACK_NONE, 1'b1, 1'b0);
		run_request(OP_STAT_RD, 8'($urandom), 0, NACK_NONE, 1'b1, 1'b0);
		c.timeout_polls = 16'd0;
		program_cfg(c);
		run_request(OP_HUMI, 8'($urandom), 0, NACK_NONE, 1'b0, 1'b0);
	endtask

	task automatic test_cfg_extremes();
		cfg_t c;
		c.half_period = 8'd0;
		c.poll_interval = 16'd0;
		c.timeout_polls = 16'd1;
		c.cmd_temp = 8'h00;
		c.cmd_humi = 8'hFF;
		c.cmd_stat_rd = 8'h00;
		c.cmd_stat_wr = 8'hFF;
		c.cmd_soft = 8'h00;
		program_cfg(c);
		run_request(OP_TEMP, 8'($urandom), 0, NACK_NONE, 1'b0, 1'b0);
		run_request(OP_STAT_WR, 8'h5A, 0, NACK_NONE, 1'b0, 1'b0);
	endtask

	task automatic test_random();
		cfg_t c;
		for (int s = 0; s < 2; s++) begin
			c.half_period = 8'($urandom_range(0, 2));
			c.poll_interval = 16'($urandom_range(0, 4));
			c.timeout_polls = 16'($urandom_range(0, 5));
			c.cmd_temp = 8'($urandom);
			c.cmd_humi = 8'($urandom);
			c.cmd_stat_rd = 8'($urandom);
			c.cmd_stat_wr = 8'($urandom);
			c.cmd_soft = 8'($urandom);
			program_cfg(c);
			gaps_on = ($urandom_range(0, 3) != 0);
			run_request(3'($urandom_range(1, 5)), 8'($urandom),
				($urandom_range(0, 9) == 0) ? int'(c.timeout_polls) + 1 : $urandom_range(0, 3),
				($urandom_range(0, 11) == 0) ? 2'($urandom_range(0, 1)) : NACK_NONE,
				($urandom_range(0, 7) == 0), ($urandom_range(0, 9) == 0));
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data <= '0;
		fail_count = 0;
		gaps_on = 1'b1;
		sens_noise = 1'b0;
		nack_at = NACK_NONE;
		answer_after = 0;
		rsp_msb = '0;
		rsp_lsb = '0;
		rsp_sum = '0;
		seq_step = ST_IDLE;
		ph_timer = '0;
		bit_cnt = '0;
		byte_idx = '0;
		shreg = '0;
		req_kind = '0;
		polls = '0;
		value_q = '0;
		sum_q = '0;
		crc_q = '0;
		err_q = ERR_OK;
		bus_cfg = reset_cfg();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_ignored_ops();
		test_requests();
		test_error_paths();
		test_cfg_extremes();
		test_random();
		settle();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
